// ----- hdl/tba_pkg.sv -----
package tba_pkg;

    // Pool geometry: leaves are nodes ID_SPACE .. 2*ID_SPACE-1
    localparam int TREE_LEVELS = 10;
    localparam int ID_SPACE    = 1 << TREE_LEVELS;
    localparam int ID_W        = TREE_LEVELS;
    localparam int CNT_W       = TREE_LEVELS + 1;
    localparam int NODE_W      = TREE_LEVELS + 1;
    // One memory row holds a sibling pair: nodes 2r and 2r+1
    localparam int ROW_W       = TREE_LEVELS;
    localparam int ROWS        = ID_SPACE;
    localparam int PAIR_W      = 2;
    localparam int OP_W        = 2;
    localparam int STATUS_W    = 2;

    typedef enum logic [OP_W-1:0] {
        OP_ALLOC   = 2'd0,
        OP_RESERVE = 2'd1,
        OP_RELEASE = 2'd2
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK   = 2'd0,
        ST_USED = 2'd1,
        ST_FREE = 2'd2,
        ST_FULL = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_ROOT,
        S_DOWN,
        S_CHECK,
        S_UP,
        S_DONE
    } state_t;

    typedef struct packed {
        logic              wr_en;
        logic [ROW_W-1:0]  wr_row;
        logic [PAIR_W-1:0] wr_data;
        logic              rd_en;
        logic [ROW_W-1:0]  rd_row;
    } mem_req_t;

    typedef struct packed {
        status_t          status;
        logic [ID_W-1:0]  id_out;
        logic [CNT_W-1:0] used_count;
    } result_t;

endpackage

// ----- hdl/tba_if.sv -----
interface tba_req_if;
    import tba_pkg::*;

    logic            valid;
    logic            ready;
    logic [OP_W-1:0] opcode;
    logic [ID_W-1:0] id_in;

    modport source (output valid, output opcode, output id_in, input ready);
    modport sink (input valid, input opcode, input id_in, output ready);
endinterface

interface tba_rsp_if;
    import tba_pkg::*;

    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [ID_W-1:0]     id_out;
    logic [CNT_W-1:0]    used_count;

    modport source (output valid, output status, output id_out, output used_count,
                    input ready);
    modport sink (input valid, input status, input id_out, input used_count,
                  output ready);
endinterface

// ----- hdl/tba_tree_ram.sv -----
module tba_tree_ram #(
    parameter int ADDR_W = 10,
    parameter int DATA_W = 2
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [DATA_W-1:0] wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [DATA_W-1:0] rd_data
);

    logic [DATA_W-1:0] mem [1 << ADDR_W];
    logic [DATA_W-1:0] rd_data_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- hdl/tba_walk.sv -----
module tba_walk (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      req_valid,
    output logic                      req_ready,
    input  logic [tba_pkg::OP_W-1:0]  req_opcode,
    input  logic [tba_pkg::ID_W-1:0]  req_id,
    output logic                      done,
    input  logic                      out_free,
    output tba_pkg::result_t          result,
    output tba_pkg::mem_req_t         mem_req,
    input  logic [tba_pkg::PAIR_W-1:0] mem_rd_data
);
    import tba_pkg::*;

    state_t             state_reg, state_next;
    logic               set_reg, set_next;
    logic [NODE_W-1:0]  cur_reg, cur_next;
    status_t            status_reg, status_next;
    logic [ID_W-1:0]    id_reg, id_next;
    logic [CNT_W-1:0]   in_use_reg, in_use_next;
    logic [ROW_W-1:0]   clr_row_reg, clr_row_next;

    logic               accept;
    logic               root_full;
    logic               found;
    logic [NODE_W-1:0]  child;
    logic               child_leaf;
    logic               leaf_bit;
    logic               check_ok;
    logic               step_en;
    logic [NODE_W-1:0]  step_node;
    logic               step_set;
    logic [PAIR_W-1:0]  pair_new;
    logic               step_cont;

    assign accept = req_valid && req_ready;

    // Decode the pair just read: root bit, descent choice, leaf bit
    always_comb
    begin
        root_full  = mem_rd_data[1];
        found      = !mem_rd_data[0] || !mem_rd_data[1];
        child      = {cur_reg[NODE_W-2:0], mem_rd_data[0]};
        child_leaf = child[NODE_W-1];
        leaf_bit   = mem_rd_data[cur_reg[0]];
        check_ok   = set_reg ? !leaf_bit : leaf_bit;
    end

    // Set or clear one node in its pair and decide whether to climb
    always_comb
    begin
        step_en   = 1'b0;
        step_node = cur_reg;
        step_set  = set_reg;
        case (state_reg)
            S_DOWN:
            begin
                step_en   = found && child_leaf;
                step_node = child;
                step_set  = 1'b1;
            end
            S_CHECK: step_en = check_ok;
            S_UP:    step_en = 1'b1;
            default: step_en = 1'b0;
        endcase
        pair_new               = mem_rd_data;
        pair_new[step_node[0]] = step_set;
        step_cont = (step_node != NODE_W'(1)) && (!step_set || pair_new == 2'b11);
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_CLEAR:
            begin
                if (clr_row_reg == ROW_W'(ROWS - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (req_valid)
                begin
                    case (op_t'(req_opcode))
                        OP_ALLOC:   state_next = S_ROOT;
                        OP_RESERVE: state_next = S_CHECK;
                        OP_RELEASE: state_next = S_CHECK;
                        default:    state_next = S_DONE;
                    endcase
                end
            end
            S_ROOT:
            begin
                state_next = root_full ? S_DONE : S_DOWN;
            end
            S_DOWN:
            begin
                if (!found)
                begin
                    state_next = S_DONE;
                end
                else if (child_leaf)
                begin
                    state_next = step_cont ? S_UP : S_DONE;
                end
            end
            S_CHECK:
            begin
                state_next = (check_ok && step_cont) ? S_UP : S_DONE;
            end
            S_UP:
            begin
                state_next = step_cont ? S_UP : S_DONE;
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // Datapath and memory accesses
    always_comb
    begin
        set_next     = set_reg;
        cur_next     = cur_reg;
        status_next  = status_reg;
        id_next      = id_reg;
        in_use_next  = in_use_reg;
        clr_row_next = clr_row_reg;
        mem_req      = '0;
        req_ready    = (state_reg == S_IDLE);
        done         = (state_reg == S_DONE);

        case (state_reg)
            S_CLEAR:
            begin
                mem_req.wr_en  = 1'b1;
                mem_req.wr_row = clr_row_reg;
                mem_req.wr_data = '0;
                clr_row_next   = clr_row_reg + ROW_W'(1);
            end
            S_IDLE:
            begin
                if (accept)
                begin
                    set_next    = (op_t'(req_opcode) != OP_RELEASE);
                    cur_next    = {1'b1, req_id};
                    status_next = ST_OK;
                    id_next     = '0;
                    case (op_t'(req_opcode))
                        OP_ALLOC:
                        begin
                            mem_req.rd_en  = 1'b1;
                            mem_req.rd_row = '0;
                        end
                        OP_RESERVE, OP_RELEASE:
                        begin
                            mem_req.rd_en  = 1'b1;
                            mem_req.rd_row = {1'b1, req_id[ID_W-1:1]};
                        end
                        default: mem_req.rd_en = 1'b0;
                    endcase
                end
            end
            S_ROOT:
            begin
                if (root_full)
                begin
                    status_next = ST_FULL;
                end
                else
                begin
                    cur_next       = NODE_W'(1);
                    mem_req.rd_en  = 1'b1;
                    mem_req.rd_row = ROW_W'(1);
                end
            end
            S_DOWN:
            begin
                if (!found)
                begin
                    status_next = ST_FULL;
                end
                else if (child_leaf)
                begin
                    id_next = child[ID_W-1:0];
                end
                else
                begin
                    cur_next       = child;
                    mem_req.rd_en  = 1'b1;
                    mem_req.rd_row = child[ROW_W-1:0];
                end
            end
            S_CHECK:
            begin
                if (!check_ok)
                begin
                    status_next = set_reg ? ST_USED : ST_FREE;
                end
            end
            default:
            begin
            end
        endcase

        // Write back the modified pair, then climb or close the count
        if (step_en)
        begin
            mem_req.wr_en   = 1'b1;
            mem_req.wr_row  = step_node[NODE_W-1:1];
            mem_req.wr_data = pair_new;
            if (step_cont)
            begin
                cur_next       = {1'b0, step_node[NODE_W-1:1]};
                mem_req.rd_en  = 1'b1;
                mem_req.rd_row = {1'b0, step_node[NODE_W-1:2]};
            end
            else
            begin
                in_use_next = step_set ? in_use_reg + CNT_W'(1) : in_use_reg - CNT_W'(1);
            end
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_CLEAR;
            in_use_reg  <= '0;
            clr_row_reg <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            in_use_reg  <= in_use_next;
            clr_row_reg <= clr_row_next;
        end
    end

    // Operation payload
    always_ff @(posedge clk)
    begin
        set_reg    <= set_next;
        cur_reg    <= cur_next;
        status_reg <= status_next;
        id_reg     <= id_next;
    end

    assign result.status     = status_reg;
    assign result.id_out     = id_reg;
    assign result.used_count = in_use_reg;

    // A pair is never written and read back in the same cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        mem_req.wr_en && mem_req.rd_en |-> mem_req.wr_row != mem_req.rd_row)
        else $error("tree row written and read in one cycle");

    // The count never passes the pool size
    assert property (@(posedge clk) disable iff (!rst_n)
        in_use_reg <= CNT_W'(ID_SPACE))
        else $error("used count beyond pool size");

    // The count moves only as an operation finishes its walk
    assert property (@(posedge clk) disable iff (!rst_n)
        in_use_reg != $past(in_use_reg) |-> state_reg == S_DONE)
        else $error("used count changed outside a finished walk");

    // The clear pass neither reads the tree nor takes a beat
    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_CLEAR |-> !mem_req.rd_en && !req_ready)
        else $error("activity during clear pass");

endmodule

// ----- hdl/tree_bitmap_id_allocator_top.sv -----
// Channel  Role   Payload                               Accepted when
// req      sink   opcode[1:0], id_in[9:0]               valid && ready
// rsp      source status[1:0], id_out[9:0],             valid && ready
//                 used_count[10:0]
//
// After reset a clear pass writes all 1024 sibling-pair rows of the tree
// memory with req.ready low.
// Reserve, release and allocate walk one tree level per cycle through the
// one read port and one write port of the tree memory, down from the root
// for allocate, then up from the leaf while ancestors change.
// One operation is in flight at a time; a new beat is taken while a finished
// result still waits in the rsp register, and a stalled rsp holds the next one.
module tree_bitmap_id_allocator_top (
    input logic       clk,
    input logic       rst_n,
    tba_req_if.sink   req,
    tba_rsp_if.source rsp
);
    import tba_pkg::*;

    mem_req_t          mem_req;
    logic [PAIR_W-1:0] mem_rd_data;
    logic              done;
    logic              out_free;
    result_t           result;

    logic              rsp_valid_reg, rsp_valid_next;
    result_t           rsp_data_reg;

    tba_walk u_walk (
        .clk         (clk),
        .rst_n       (rst_n),
        .req_valid   (req.valid),
        .req_ready   (req.ready),
        .req_opcode  (req.opcode),
        .req_id      (req.id_in),
        .done        (done),
        .out_free    (out_free),
        .result      (result),
        .mem_req     (mem_req),
        .mem_rd_data (mem_rd_data)
    );

    tba_tree_ram #(
        .ADDR_W (ROW_W),
        .DATA_W (PAIR_W)
    ) u_tree_ram (
        .clk     (clk),
        .wr_en   (mem_req.wr_en),
        .wr_addr (mem_req.wr_row),
        .wr_data (mem_req.wr_data),
        .rd_en   (mem_req.rd_en),
        .rd_addr (mem_req.rd_row),
        .rd_data (mem_rd_data)
    );

    // Output register: load a finished result when the slot is free
    assign out_free = !rsp_valid_reg || rsp.ready;

    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        if (done && out_free)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (rsp.ready)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (done && out_free)
        begin
            rsp_data_reg <= result;
        end
    end

    assign rsp.valid      = rsp_valid_reg;
    assign rsp.status     = rsp_data_reg.status;
    assign rsp.id_out     = rsp_data_reg.id_out;
    assign rsp.used_count = rsp_data_reg.used_count;

endmodule

// ----- dv/testbench.sv -----
`timescale 1ns / 1ps

module testbench;
    import tba_pkg::*;

    // Opcode outside the defined set: the block answers it without touching the pool
    localparam logic [OP_W-1:0] OP_NONE = 2'd3;
    localparam int HOLD_CYCLES = 400;
    localparam int DRAIN_CYCLES = 40;

    typedef struct packed {
        logic [OP_W-1:0] opcode;
        logic [ID_W-1:0] id;
    } pool_cmd_t;

    logic clk;
    logic rst_n;

    tba_req_if req ();
    tba_rsp_if rsp ();

    tree_bitmap_id_allocator_top dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rsp   (rsp)
    );

    // Mirror of the pool: full bits per tree node and the number of IDs taken
    bit alloc_full [2*ID_SPACE];
    int ids_in_use = 0;

    pool_cmd_t op_backlog [$];
    result_t due_results [$];

    int src_idle_pct = 0;
    int rsp_stall_pct = 0;
    int hold_requests = 0;
    int holds_served;
    int hold_left;
    logic req_beat;
    int mismatches = 0;
    int items_sent = 0;
    int replies_seen = 0;

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    initial
    begin
        rst_n = 1'b0;
        req.valid = 1'b0;
        req.opcode = OP_ALLOC;
        req.id_in = '0;
        rsp.ready = 1'b0;
        repeat (5) @(negedge clk);
        rst_n <= 1'b1;
    end

    initial
    begin
        #5_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

    // Set a leaf and propagate full upward while both siblings are full
    function automatic void mark_id(int id);
        int n;
        int lvl;
        n = id + ID_SPACE;
        alloc_full[n] = 1'b1;
        for (lvl = 0; lvl < TREE_LEVELS; lvl++)
        begin
            n = n >> 1;
            if (alloc_full[2*n] && alloc_full[2*n+1])
                alloc_full[n] = 1'b1;
            else
                break;
        end
        ids_in_use++;
    endfunction

    // Apply one operation to the mirror and return the reply it must produce
    function automatic result_t predict_outcome(logic [OP_W-1:0] opcode,
                                                logic [ID_W-1:0] id);
        result_t res;
        int n;
        int lvl;
        bit ok;
        res.status = ST_OK;
        res.id_out = '0;
        case (opcode)
            OP_ALLOC:
            begin
                n = 1;
                ok = !alloc_full[1];
                for (lvl = 0; ok && lvl < TREE_LEVELS; lvl++)
                begin
                    if (!alloc_full[2*n])
                        n = 2*n;
                    else if (!alloc_full[2*n+1])
                        n = 2*n + 1;
                    else
                        ok = 1'b0;
                end
                if (ok)
                begin
                    res.id_out = ID_W'(n - ID_SPACE);
                    mark_id(n - ID_SPACE);
                end
                else
                    res.status = ST_FULL;
            end
            OP_RESERVE:
            begin
                if (alloc_full[int'(id) + ID_SPACE])
                    res.status = ST_USED;
                else
                    mark_id(int'(id));
            end
            OP_RELEASE:
            begin
                if (!alloc_full[int'(id) + ID_SPACE])
                    res.status = ST_FREE;
                else
                begin
                    // A freed leaf makes every ancestor non-full
                    n = int'(id) + ID_SPACE;
                    alloc_full[n] = 1'b0;
                    for (lvl = 0; lvl < TREE_LEVELS; lvl++)
                    begin
                        n = n >> 1;
                        alloc_full[n] = 1'b0;
                    end
                    ids_in_use--;
                end
            end
            default:
            begin
            end
        endcase
        res.used_count = CNT_W'(ids_in_use);
        return res;
    endfunction

    // Find an ID currently in use, scanning from a random start
    function automatic logic [ID_W-1:0] pick_used_id();
        int start;
        int k;
        int idx;
        start = $urandom_range(ID_SPACE-1);
        for (k = 0; k < ID_SPACE; k++)
        begin
            idx = (start + k) % ID_SPACE;
            if (alloc_full[idx + ID_SPACE])
                return ID_W'(idx);
        end
        return ID_W'(start);
    endfunction

    task automatic push_item(logic [OP_W-1:0] opcode, logic [ID_W-1:0] id);
        pool_cmd_t cmd;
        cmd.opcode = opcode;
        cmd.id = id;
        while (op_backlog.size() >= 2)
            @(negedge clk);
        op_backlog.push_back(cmd);
        items_sent++;
    endtask

    // Change the idle pattern at a rising edge, resume at the falling one
    task automatic set_pace(int src_pct, int snk_pct, bit long_hold);
        @(posedge clk);
        src_idle_pct = src_pct;
        rsp_stall_pct = snk_pct;
        if (long_hold)
            hold_requests++;
        @(negedge clk);
    endtask

    // Random operations; most releases and some reserves target IDs already taken
    task automatic queue_mixed(int count, int w_alloc, int w_reserve);
        int pick;
        logic [ID_W-1:0] id;
        repeat (count)
        begin
            pick = $urandom_range(99);
            id = ID_W'($urandom_range(ID_SPACE-1));
            if (pick < w_alloc)
                push_item(OP_ALLOC, id);
            else if (pick < w_alloc + w_reserve)
                push_item(OP_RESERVE, ($urandom_range(3) == 0) ? pick_used_id() : id);
            else
                push_item(OP_RELEASE, ($urandom_range(4) != 0) ? pick_used_id() : id);
        end
    endtask

    // Stimulus sequence and end of run
    initial
    begin
        set_pace(0, 0, 1'b0);
        push_item(OP_ALLOC, 10'h000);
        push_item(OP_ALLOC, 10'h3FF);
        push_item(OP_RESERVE, 10'h3FF);
        push_item(OP_RESERVE, 10'h3FF);
        push_item(OP_RESERVE, 10'h000);
        push_item(OP_RELEASE, 10'h3FF);
        push_item(OP_RELEASE, 10'h3FF);
        push_item(OP_RELEASE, 10'h200);
        push_item(OP_RESERVE, 10'h200);
        push_item(OP_RESERVE, 10'h201);
        push_item(OP_ALLOC, 10'h155);
        push_item(OP_RELEASE, 10'h000);
        push_item(OP_ALLOC, 10'h2AA);
        push_item(OP_NONE, 10'h3FF);
        push_item(OP_NONE, 10'h000);
        push_item(OP_RESERVE, 10'h002);
        push_item(OP_RELEASE, 10'h002);
        push_item(OP_RESERVE, 10'h002);
        push_item(OP_RELEASE, 10'h001);
        push_item(OP_RELEASE, 10'h200);
        push_item(OP_ALLOC, 10'h000);
        push_item(OP_RELEASE, 10'h201);
        push_item(OP_ALLOC, 10'h3FF);

        queue_mixed(100, 40, 30);
        set_pace(74, 0, 1'b0);
        queue_mixed(100, 40, 30);
        set_pace(0, 74, 1'b1);
        queue_mixed(100, 40, 30);

        // Fill the pool completely, then work around the exhausted state
        set_pace(27, 27, 1'b0);
        while (ids_in_use < ID_SPACE)
            queue_mixed(1, 90, 6);
        queue_mixed(60, 45, 25);

        while (replies_seen < items_sent)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    // Request driver: hold the beat until taken, then offer the next or idle
    always @(negedge clk)
    begin
        pool_cmd_t cmd;
        if (!rst_n)
            req.valid <= 1'b0;
        else if (!req.valid || req_beat)
        begin
            if (op_backlog.size() != 0 && $urandom_range(99) >= src_idle_pct)
            begin
                cmd = op_backlog.pop_front();
                req.valid <= 1'b1;
                req.opcode <= cmd.opcode;
                req.id_in <= cmd.id;
            end
            else
                req.valid <= 1'b0;
        end
    end

    // Long reply hold-off, counted here so the sender keeps pushing meanwhile
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            hold_left <= 0;
            holds_served <= 0;
        end
        else if (holds_served != hold_requests)
        begin
            hold_left <= HOLD_CYCLES;
            holds_served <= holds_served + 1;
        end
        else if (hold_left != 0)
            hold_left <= hold_left - 1;
    end

    // Reply sink: stall at random and during the hold-off
    always @(negedge clk)
    begin
        rsp.ready <= rst_n && hold_left == 0 && $urandom_range(99) >= rsp_stall_pct;
    end

    // Monitor: predict on each request beat, check each reply beat
    always @(posedge clk)
    begin
        result_t want;
        req_beat <= rst_n && req.valid && req.ready;
        if (rst_n && req.valid && req.ready)
            due_results.push_back(predict_outcome(req.opcode, req.id_in));
        if (rst_n && rsp.valid && rsp.ready)
        begin
            replies_seen++;
            if (due_results.size() == 0)
            begin
                mismatches++;
                $display("%0t: unexpected reply: expected none, got status %0d id %0d count %0d",
                         $time, rsp.status, rsp.id_out, rsp.used_count);
            end
            else
            begin
                want = due_results.pop_front();
                if (rsp.status !== want.status)
                begin
                    mismatches++;
                    $display("%0t: status mismatch: expected %0d, got %0d",
                             $time, want.status, rsp.status);
                end
                if (rsp.id_out !== want.id_out)
                begin
                    mismatches++;
                    $display("%0t: id_out mismatch: expected %0d, got %0d",
                             $time, want.id_out, rsp.id_out);
                end
                if (rsp.used_count !== want.used_count)
                begin
                    mismatches++;
                    $display("%0t: used_count mismatch: expected %0d, got %0d",
                             $time, want.used_count, rsp.used_count);
                end
            end
        end
    end

endmodule

// ----- sim.f -----
hdl/tba_pkg.sv
hdl/tba_if.sv
hdl/tba_tree_ram.sv
hdl/tba_walk.sv
hdl/tree_bitmap_id_allocator_top.sv
dv/testbench.sv
